// ----- hdl/pidhb_pkg.sv -----
package pidhb_pkg;

  // Register map, one 32-bit register per word address.
  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_DEAD_BAND      = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_DRIVE_LIMIT    = 3'd5,
    REG_DUTY_MAX       = 3'd6
  } pidhb_reg_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] dead_band;
    logic [29:0] integral_limit;
    logic [14:0] drive_limit;
    logic [14:0] duty_max;
  } pidhb_cfg_t;

  localparam logic [29:0] INTEGRAL_LIMIT_RST = 30'h3FFF_FFFF;
  localparam logic [14:0] DRIVE_LIMIT_RST    = 15'h7FFF;
  localparam logic [14:0] DUTY_MAX_RST       = 15'h7FFF;

  // Divide by ten of a 47-bit magnitude m = h*2^24 + l:
  //   m/10 = h*HI_QUOT + floor((h*HI_REM + l)/10)
  // where 2^24 = 10*HI_QUOT + HI_REM. The second term has a value below 2^26
  // and is divided by a reciprocal multiply that is exact over that range.
  localparam int          DIV_SPLIT   = 24;
  localparam logic [20:0] HI_QUOT     = 21'd1677721;
  localparam logic [25:0] RECIP_TEN   = 26'd53687092;
  localparam int          RECIP_SHIFT = 29;

endpackage

// ----- hdl/pidhb_regs.sv -----
module pidhb_regs
  import pidhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pidhb_cfg_t  cfg
);

  pidhb_reg_t sel_reg;
  logic       wr_en;

  assign pready  = 1'b1;
  assign sel_reg = pidhb_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.dead_band      <= '0;
      cfg.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg.drive_limit    <= DRIVE_LIMIT_RST;
      cfg.duty_max       <= DUTY_MAX_RST;
    end else if (wr_en) begin
      case (sel_reg)
        REG_GAIN_P:         cfg.gain_p         <= pwdata[15:0];
        REG_GAIN_I:         cfg.gain_i         <= pwdata[15:0];
        REG_GAIN_D:         cfg.gain_d         <= pwdata[15:0];
        REG_DEAD_BAND:      cfg.dead_band      <= pwdata[15:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= pwdata[29:0];
        REG_DRIVE_LIMIT:    cfg.drive_limit    <= pwdata[14:0];
        REG_DUTY_MAX:       cfg.duty_max       <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_reg)
      REG_GAIN_P:         prdata = {16'd0, cfg.gain_p};
      REG_GAIN_I:         prdata = {16'd0, cfg.gain_i};
      REG_GAIN_D:         prdata = {16'd0, cfg.gain_d};
      REG_DEAD_BAND:      prdata = {16'd0, cfg.dead_band};
      REG_INTEGRAL_LIMIT: prdata = {2'd0, cfg.integral_limit};
      REG_DRIVE_LIMIT:    prdata = {17'd0, cfg.drive_limit};
      REG_DUTY_MAX:       prdata = {17'd0, cfg.duty_max};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/pid_speed_loop_with_hbridge_drive_core.sv -----
// Speed loop for one motor: positional PID with deadband, integral clamp and
// output clamp, followed by PWM saturation and H-bridge direction split. One
// word is accepted every cycle unless m_tready back-pressure fills the path,
// which is an input register followed by eight stages (error and integral
// update, the three gain products, their sum, magnitude, two steps of the
// divide by ten, drive clamp, output register). Integral and previous error
// are updated in the first stage, so consecutive words need no
// spacing. Stages advance independently, so input words are still taken while
// a result waits on the output, until all nine registers hold words.
module pid_speed_loop_with_hbridge_drive_core
  import pidhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [15:0] setpoint, [31:16] measured_speed
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // [15:0] drive_value, [16] bridge_a, [17] bridge_b,
                                // [32:18] duty, [39:33] zero
);

  localparam int LAST = 8;

  pidhb_cfg_t cfg;

  pidhb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [LAST:0] vld;
  logic [LAST:0] rdy;

  always_comb begin
    rdy[LAST] = !vld[LAST] || m_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[LAST];

  // Stage 0: input register.
  logic signed [15:0] s0_sp;
  logic signed [15:0] s0_ms;

  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) begin
      s0_sp <= s_tdata[15:0];
      s0_ms <= s_tdata[31:16];
    end
  end

  // Stage 1: error, deadband test and the integral/previous-error update.
  logic signed [30:0] error_sum;
  logic signed [16:0] last_error;

  logic signed [16:0] err;
  logic        [16:0] err_mag;
  logic               upd;
  logic signed [31:0] sum_raw;
  logic signed [31:0] ilim;
  logic signed [31:0] ilim_neg;
  logic signed [30:0] esum_new;
  logic signed [17:0] derr;

  always_comb begin
    err      = s0_sp - s0_ms;
    err_mag  = err[16] ? 17'(-err) : err;
    upd      = !(err_mag < {1'b0, cfg.dead_band});
    sum_raw  = error_sum + err;
    ilim     = $signed({2'b00, cfg.integral_limit});
    ilim_neg = -ilim;
    if (sum_raw > ilim) begin
      esum_new = ilim[30:0];
    end else if (sum_raw < ilim_neg) begin
      esum_new = ilim_neg[30:0];
    end else begin
      esum_new = sum_raw[30:0];
    end
    derr = err - last_error;
  end

  logic               s1_upd;
  logic signed [16:0] s1_err;
  logic signed [17:0] s1_derr;
  logic signed [30:0] s1_esum;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (rdy[1] && vld[0] && upd) begin
      error_sum  <= esum_new;
      last_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      s1_upd  <= upd;
      s1_err  <= err;
      s1_derr <= derr;
      s1_esum <= esum_new;
    end
  end

  // Stage 2: the three gain products.
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [33:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [34:0] prod_d;

  always_comb begin
    kp_s   = $signed({1'b0, cfg.gain_p});
    ki_s   = $signed({1'b0, cfg.gain_i});
    kd_s   = $signed({1'b0, cfg.gain_d});
    prod_p = kp_s * s1_err;
    prod_i = ki_s * s1_esum;
    prod_d = kd_s * s1_derr;
  end

  logic               s2_upd;
  logic signed [33:0] s2_pp;
  logic signed [47:0] s2_pi;
  logic signed [34:0] s2_pd;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      s2_upd <= s1_upd;
      s2_pp  <= prod_p;
      s2_pi  <= prod_i;
      s2_pd  <= prod_d;
    end
  end

  // Stage 3: sum of the products.
  logic               s3_upd;
  logic signed [47:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      s3_upd <= s2_upd;
      s3_sum <= s2_pp + s2_pi + s2_pd;
    end
  end

  // Stage 4: sign and magnitude, so the quotient truncates toward zero.
  logic signed [47:0] sum_neg;
  logic               s4_upd;
  logic               s4_neg;
  logic        [46:0] s4_mag;

  assign sum_neg = -s3_sum;

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      s4_upd <= s3_upd;
      s4_neg <= s3_sum[47];
      s4_mag <= s3_sum[47] ? sum_neg[46:0] : s3_sum[46:0];
    end
  end

  // Stage 5: split the magnitude for the divide by ten.
  logic [22:0] mag_hi;
  logic [23:0] mag_lo;
  logic [25:0] rem_part;

  always_comb begin
    mag_hi   = s4_mag[46:DIV_SPLIT];
    mag_lo   = s4_mag[DIV_SPLIT-1:0];
    rem_part = {1'b0, mag_hi, 2'b00} + {2'b00, mag_hi, 1'b0} + {2'b00, mag_lo};
  end

  logic        s5_upd;
  logic        s5_neg;
  logic [43:0] s5_qhi;
  logic [25:0] s5_rem;

  always_ff @(posedge clk) begin
    if (rdy[5] && vld[4]) begin
      s5_upd <= s4_upd;
      s5_neg <= s4_neg;
      s5_qhi <= mag_hi * HI_QUOT;
      s5_rem <= rem_part;
    end
  end

  // Stage 6: reciprocal multiply for the low part.
  logic [51:0] recip_prod;

  assign recip_prod = s5_rem * RECIP_TEN;

  logic        s6_upd;
  logic        s6_neg;
  logic [43:0] s6_qhi;
  logic [22:0] s6_qlo;

  always_ff @(posedge clk) begin
    if (rdy[6] && vld[5]) begin
      s6_upd <= s5_upd;
      s6_neg <= s5_neg;
      s6_qhi <= s5_qhi;
      s6_qlo <= recip_prod[RECIP_SHIFT+22:RECIP_SHIFT];
    end
  end

  // Stage 7: quotient and drive limit.
  logic        [43:0] quot;
  logic        [14:0] quot_c;
  logic signed [15:0] quot_s;

  always_comb begin
    quot   = s6_qhi + {21'd0, s6_qlo};
    quot_c = (quot > {29'd0, cfg.drive_limit}) ? cfg.drive_limit : quot[14:0];
    quot_s = $signed({1'b0, quot_c});
  end

  logic               s7_upd;
  logic signed [15:0] s7_drv;

  always_ff @(posedge clk) begin
    if (rdy[7] && vld[6]) begin
      s7_upd <= s6_upd;
      s7_drv <= s6_neg ? 16'(-quot_s) : quot_s;
    end
  end

  // Stage 8: a skipped tick repeats the last computed drive, then PWM saturation.
  logic signed [15:0] last_drive;
  logic signed [15:0] drv_sel;
  logic signed [15:0] pwm_s;
  logic signed [15:0] pwm_neg;
  logic signed [15:0] drv_sat;
  logic signed [15:0] drv_neg;

  always_comb begin
    drv_sel = s7_upd ? s7_drv : last_drive;
    pwm_s   = $signed({1'b0, cfg.duty_max});
    pwm_neg = -pwm_s;
    if (drv_sel > pwm_s) begin
      drv_sat = pwm_s;
    end else if (drv_sel < pwm_neg) begin
      drv_sat = pwm_neg;
    end else begin
      drv_sat = drv_sel;
    end
    drv_neg = -drv_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_drive <= '0;
    end else if (rdy[8] && vld[7] && s7_upd) begin
      last_drive <= s7_drv;
    end
  end

  logic signed [15:0] out_drive;
  logic        [14:0] out_duty;

  always_ff @(posedge clk) begin
    if (rdy[8] && vld[7]) begin
      out_drive <= drv_sat;
      out_duty  <= drv_sat[15] ? drv_neg[14:0] : drv_sat[14:0];
    end
  end

  assign m_tdata = {7'd0, out_duty, out_drive[15], !out_drive[15], out_drive};

endmodule
